/* hdl/spmq_pkg.sv */
// Shared types and constants for the strict-priority multi-queue.
package spmq_pkg;

	localparam int KIND_W   = 2;
	localparam int TICKET_W = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_TAKE     = 2'd0,
		KIND_APPEND   = 2'd1,
		KIND_POP      = 2'd2,
		KIND_POP_HIGH = 2'd3
	} kind_t;

	typedef logic [TICKET_W-1:0] ticket_t;

endpackage

/* hdl/spmq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module spmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/strict_priority_multi_queue.sv */
// Top level of the strict-priority multi-queue ticket dispenser.
//
//  channel   | handshake            | fields
//  ----------+----------------------+---------------------------------------------------
//  command   | start / busy         | kind, queue_index, ticket_in
//  result    | done (one-cycle)     | ticket_out, found, served_queue, overflow,
//            |                      | queue_count, total_count
//
// One item is taken in every cycle; busy is always low.
// The result of an item appears in the cycle after it is taken, matching the registered
// read port of the queue store RAM.
// Reset clears pointers, occupancies and the done strobe, and sets the ticket counter to one.
// The receiver cannot stall: each result is shown for exactly one cycle.
module strict_priority_multi_queue #(
	parameter int NUM_LEVELS  = 3,
	parameter int QUEUE_DEPTH = 16,
	localparam int LVL_W = ($clog2(NUM_LEVELS) < 2) ? 2 : $clog2(NUM_LEVELS),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int TOT_W = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  spmq_pkg::kind_t     kind,
	input  logic [LVL_W-1:0]    queue_index,
	input  spmq_pkg::ticket_t   ticket_in,
	output logic                done,
	output spmq_pkg::ticket_t   ticket_out,
	output logic                found,
	output logic [LVL_W-1:0]    served_queue,
	output logic                overflow,
	output logic [CNT_W-1:0]    queue_count,
	output logic [TOT_W-1:0]    total_count
);

	import spmq_pkg::*;

	localparam int LIDX_W = $clog2(NUM_LEVELS);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int WORDS  = NUM_LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(WORDS);

	logic [CNT_W-1:0]  occ_q  [NUM_LEVELS];
	logic [PTR_W-1:0]  head_q [NUM_LEVELS];
	logic [PTR_W-1:0]  tail_q [NUM_LEVELS];
	logic [TOT_W-1:0]  total_q;
	ticket_t           ticket_q;

	logic              done_s1;
	logic              pop_s1;
	logic              found_s1;
	ticket_t           ticket_s1;
	logic [LVL_W-1:0]  served_s1;
	logic              ovf_s1;
	logic [CNT_W-1:0]  qcnt_s1;
	logic [TOT_W-1:0]  total_s1;

	logic              accept;
	logic              lvl_ok;
	logic              any_held;
	logic [LIDX_W-1:0] hi_lvl;
	logic [LIDX_W-1:0] op_lvl;
	logic [CNT_W-1:0]  cur_occ;
	logic [CNT_W-1:0]  new_occ;
	logic              is_full;
	logic              do_push;
	logic              do_pop;
	logic [TOT_W-1:0]  new_total;
	logic [CNT_W-1:0]  qcnt_d;
	logic [LVL_W-1:0]  served_d;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	ticket_t           rd_data;
	logic [TOT_W-1:0]  occ_sum;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign lvl_ok = {1'b0, queue_index} < (LVL_W + 1)'(NUM_LEVELS);

	always_comb begin
		hi_lvl   = '0;
		any_held = 1'b0;
		for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
			if (occ_q[lv] != '0) begin
				hi_lvl   = LIDX_W'(lv);
				any_held = 1'b1;
			end
		end
	end

	assign op_lvl  = (kind == KIND_POP_HIGH) ? hi_lvl : queue_index[LIDX_W-1:0];
	assign cur_occ = occ_q[op_lvl];
	assign is_full = cur_occ == CNT_W'(QUEUE_DEPTH);

	assign do_push = accept && kind == KIND_APPEND && lvl_ok && !is_full;
	assign do_pop  = accept && ((kind == KIND_POP && lvl_ok && cur_occ != '0) ||
	                            (kind == KIND_POP_HIGH && any_held));

	assign new_occ   = cur_occ + CNT_W'(do_push) - CNT_W'(do_pop);
	assign new_total = total_q + TOT_W'(do_push) - TOT_W'(do_pop);

	always_comb begin
		qcnt_d   = '0;
		served_d = '0;
		case (kind)
			KIND_TAKE: begin
				qcnt_d   = '0;
				served_d = '0;
			end
			KIND_APPEND, KIND_POP: begin
				served_d = queue_index;
				qcnt_d   = lvl_ok ? new_occ : '0;
			end
			KIND_POP_HIGH: begin
				served_d = LVL_W'(hi_lvl);
				qcnt_d   = new_occ;
			end
			default: begin
				qcnt_d   = '0;
				served_d = '0;
			end
		endcase
	end

	assign waddr = ADDR_W'(op_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[op_lvl]);
	assign raddr = ADDR_W'(op_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[op_lvl]);

	spmq_ram #(
		.WIDTH (TICKET_W),
		.DEPTH (WORDS)
	) u_store (
		.clk   (clk),
		.we    (do_push),
		.waddr (waddr),
		.wdata (ticket_in),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int lv = 0; lv < NUM_LEVELS; lv++) begin
				occ_q[lv]  <= '0;
				head_q[lv] <= '0;
				tail_q[lv] <= '0;
			end
			total_q  <= '0;
			ticket_q <= ticket_t'(1);
			done_s1  <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept && kind == KIND_TAKE) begin
				ticket_q <= ticket_q + ticket_t'(1);
			end
			if (do_push || do_pop) begin
				occ_q[op_lvl] <= new_occ;
				total_q       <= new_total;
			end
			if (do_push) begin
				tail_q[op_lvl] <= (tail_q[op_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ?
				                  '0 : tail_q[op_lvl] + PTR_W'(1);
			end
			if (do_pop) begin
				head_q[op_lvl] <= (head_q[op_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ?
				                  '0 : head_q[op_lvl] + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1    <= do_pop;
			found_s1  <= do_pop || kind == KIND_TAKE;
			ticket_s1 <= (kind == KIND_TAKE) ? ticket_q : '0;
			served_s1 <= served_d;
			ovf_s1    <= kind == KIND_APPEND && lvl_ok && is_full;
			qcnt_s1   <= qcnt_d;
			total_s1  <= new_total;
		end
	end

	assign done         = done_s1;
	assign ticket_out   = pop_s1 ? rd_data : ticket_s1;
	assign found        = found_s1;
	assign served_queue = served_s1;
	assign overflow     = ovf_s1;
	assign queue_count  = qcnt_s1;
	assign total_count  = total_s1;

	always_comb begin
		occ_sum = '0;
		for (int lv = 0; lv < NUM_LEVELS; lv++) begin
			occ_sum = occ_sum + TOT_W'(occ_q[lv]);
		end
	end

`ifndef ASSERT_OFF
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == occ_sum)
		else $error("total occupancy differs from sum of levels");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("taken item gave no result");

	a_ovf_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (!found && queue_count == CNT_W'(QUEUE_DEPTH)))
		else $error("dropped append reported wrongly");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_push && do_pop))
		else $error("push and pop in one item");
`endif

endmodule
